// ===== hdl/agbk_pkg.sv =====
// ----------------------------------------------------------------------------
// agbk_pkg: shared types and constants of the angle/gyro-bias Kalman core
// Holds the controller state and step codes, the command and status structs,
// the register reset values and the saturation helpers.
// ----------------------------------------------------------------------------
package agbk_pkg;

    // Width of the narrow multiplier operand and of the divisor (signed Q4.28
    // sums of up to three terms).
    localparam int NW = 34;
    // Quotient bits produced by the divider; larger quotients saturate.
    localparam int QBITS = 31;
    // Width of a rounded product.
    localparam int RES_W = 64;
    // Fraction bits of Q4.28.
    localparam int FRAC = 28;
    // Bits of the wide operand taken per multiplier cycle.
    localparam int CHUNK = 16;

    localparam logic [28:0] RST_Q_ANGLE = 29'd268435;
    localparam logic [28:0] RST_Q_BIAS  = 29'd805306;
    localparam logic [31:0] RST_R       = 32'd134217728;
    localparam logic [28:0] RST_DT      = 29'd1342177;
    localparam logic signed [31:0] Q28_ONE = 32'sd268435456;
    localparam logic [63:0] MAG_LIMIT = 64'h4000_0000_0000_0000;

    typedef enum logic [1:0] {
        CFG_Q_ANGLE = 2'd0,
        CFG_Q_BIAS  = 2'd1,
        CFG_R       = 2'd2,
        CFG_DT      = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MWAIT,
        ST_DWAIT,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        STEP_ANG_P,
        STEP_P00,
        STEP_P01,
        STEP_P11,
        STEP_K0,
        STEP_K1,
        STEP_C_P00,
        STEP_C_P01,
        STEP_C_P10,
        STEP_C_P11,
        STEP_C_ANG,
        STEP_C_BIAS
    } step_t;

    typedef struct packed {
        step_t step;
        logic  capture;
        logic  mul_start;
        logic  div_start;
        logic  wb;
        logic  out_load;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic out_busy;
    } status_t;

    // Saturate a 64-bit signed value to signed 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Steps that use the divider rather than the multiplier.
    function automatic logic is_div(input step_t s);
        return (s == STEP_K0) || (s == STEP_K1);
    endfunction

    // Fixed order of the work for one sample.
    function automatic step_t next_step(input step_t s);
        step_t n;
        unique case (s)
            STEP_ANG_P:  n = STEP_P00;
            STEP_P00:    n = STEP_P01;
            STEP_P01:    n = STEP_P11;
            STEP_P11:    n = STEP_K0;
            STEP_K0:     n = STEP_K1;
            STEP_K1:     n = STEP_C_P00;
            STEP_C_P00:  n = STEP_C_P01;
            STEP_C_P01:  n = STEP_C_P10;
            STEP_C_P10:  n = STEP_C_P11;
            STEP_C_P11:  n = STEP_C_ANG;
            STEP_C_ANG:  n = STEP_C_BIAS;
            default:     n = STEP_ANG_P;
        endcase
        return n;
    endfunction

endpackage

// ===== hdl/agbk_mul.sv =====
// ----------------------------------------------------------------------------
// agbk_mul: sequential Q4.28 multiplier
// Multiplies magnitudes 16 bits of the wide operand per cycle, then rounds
// to nearest with ties away from zero, caps the magnitude and applies sign.
// ----------------------------------------------------------------------------
module agbk_mul #(
    parameter int WW = 34
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [WW-1:0]                a,
    input  logic signed [agbk_pkg::NW-1:0]      b,
    output logic                                done,
    output logic signed [agbk_pkg::RES_W-1:0]   res
);

    localparam int NCH = (WW + agbk_pkg::CHUNK - 1) / agbk_pkg::CHUNK;
    localparam int AMW = NCH * agbk_pkg::CHUNK;
    localparam int PW  = AMW + agbk_pkg::NW;
    localparam int SW  = (PW + 1 - agbk_pkg::FRAC > agbk_pkg::RES_W) ?
                         (PW + 1 - agbk_pkg::FRAC) : agbk_pkg::RES_W;
    localparam int CW  = $clog2(NCH + 1);

    logic [AMW-1:0]              amag_reg;
    logic [agbk_pkg::NW-1:0]     bmag_reg;
    logic                        neg_reg;
    logic [PW-1:0]               acc_reg;
    logic [CW-1:0]               cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic signed [agbk_pkg::RES_W-1:0] res_reg;

    logic [WW-1:0]                         a_mag;
    logic [agbk_pkg::NW-1:0]               b_mag;
    logic [agbk_pkg::CHUNK+agbk_pkg::NW-1:0] part;
    logic [PW:0]                           rnd;
    logic [SW-1:0]                         shr;
    logic [agbk_pkg::RES_W-1:0]            mag;

    // Operand magnitudes and the partial product of the current chunk.
    assign a_mag = a[WW-1] ? $unsigned(-a) : $unsigned(a);
    assign b_mag = b[agbk_pkg::NW-1] ? $unsigned(-b) : $unsigned(b);
    assign part  = amag_reg[AMW-1 -: agbk_pkg::CHUNK] * bmag_reg;

    // Rounding and magnitude cap of the finished product.
    assign rnd = {1'b0, acc_reg} + ((PW + 1)'(1) << (agbk_pkg::FRAC - 1));
    assign shr = SW'(rnd >> agbk_pkg::FRAC);
    assign mag = (shr > SW'(agbk_pkg::MAG_LIMIT)) ? agbk_pkg::MAG_LIMIT : shr[agbk_pkg::RES_W-1:0];

    // Control: chunk counter, busy and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NCH);
            end
            else if (busy_reg)
            begin
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift-accumulate, then the rounded signed result.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            amag_reg <= AMW'(a_mag);
            bmag_reg <= b_mag;
            neg_reg  <= a[WW-1] ^ b[agbk_pkg::NW-1];
            acc_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                acc_reg  <= (acc_reg << agbk_pkg::CHUNK) + PW'(part);
                amag_reg <= amag_reg << agbk_pkg::CHUNK;
            end
            else
            begin
                res_reg <= neg_reg ? -$signed(mag) : $signed(mag);
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ===== hdl/agbk_div.sv =====
// ----------------------------------------------------------------------------
// agbk_div: radix-2 gain divider
// Computes sat32(num * 2^28 / den), truncating toward zero, for a positive
// divisor. One quotient bit per cycle after a single saturation check.
// ----------------------------------------------------------------------------
module agbk_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [31:0]              num,
    input  logic [agbk_pkg::NW-1:0]         den,
    output logic                            done,
    output logic signed [31:0]              quo
);

    localparam int NMW = 32 + agbk_pkg::FRAC;
    localparam int CW  = $clog2(agbk_pkg::QBITS + 1);

    logic [agbk_pkg::NW:0]          rem_reg;
    logic [agbk_pkg::QBITS-1:0]     low_reg;
    logic [agbk_pkg::QBITS-1:0]     q_reg;
    logic [agbk_pkg::NW-1:0]        den_reg;
    logic                           neg_reg;
    logic                           sat_reg;
    logic [CW-1:0]                  cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [31:0]                    num_mag;
    logic [NMW-1:0]                 nm;
    logic [agbk_pkg::NW+agbk_pkg::QBITS-1:0] big;
    logic [agbk_pkg::NW:0]          trial;
    logic                           fits;

    // Scaled numerator magnitude; a quotient of 2^31 or more saturates.
    assign num_mag = num[31] ? $unsigned(-num) : $unsigned(num);
    assign nm      = {num_mag, {agbk_pkg::FRAC{1'b0}}};
    assign big     = {den, {agbk_pkg::QBITS{1'b0}}};

    // One restoring step.
    assign trial = {rem_reg[agbk_pkg::NW-1:0], low_reg[agbk_pkg::QBITS-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(agbk_pkg::QBITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= (agbk_pkg::NW + 1)'(nm[NMW-1:agbk_pkg::QBITS]);
            low_reg <= nm[agbk_pkg::QBITS-1:0];
            q_reg   <= '0;
            den_reg <= den;
            neg_reg <= num[31];
            sat_reg <= (agbk_pkg::NW + agbk_pkg::QBITS)'(nm) >= big;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (trial - {1'b0, den_reg}) : trial;
            q_reg   <= {q_reg[agbk_pkg::QBITS-2:0], fits};
            low_reg <= low_reg << 1;
        end
    end

    // Signed, saturated quotient.
    always_comb
    begin
        if (sat_reg)
        begin
            quo = neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            quo = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
        end
    end

    assign done = done_reg;

endmodule

// ===== hdl/agbk_dp.sv =====
// ----------------------------------------------------------------------------
// agbk_dp: filter datapath
// Holds the configuration, the filter state and the result register, feeds
// the multiplier and the divider and writes back each step's result.
// ----------------------------------------------------------------------------
module agbk_dp #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  agbk_pkg::cmd_t        cmd,
    output agbk_pkg::status_t     status,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic signed [31:0]    accel_angle,
    input  logic signed [31:0]    gyro_rate,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [31:0]    angle_est,
    output logic signed [31:0]    rate_est
);

    localparam int WW = (DATA_WIDTH + 2 > agbk_pkg::NW) ? DATA_WIDTH + 2 : agbk_pkg::NW;
    // Innovation width: holds a 32-bit angle minus a state of either width.
    localparam int EW = (DATA_WIDTH + 1 > 33) ? DATA_WIDTH + 1 : 33;
    localparam logic signed [63:0] DW_MAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] DW_MIN = -DW_MAX - 64'sd1;

    function automatic logic signed [DATA_WIDTH-1:0] sat_dw(input logic signed [63:0] v);
        logic signed [DATA_WIDTH-1:0] r;
        if (v > DW_MAX) begin
            r = DW_MAX[DATA_WIDTH-1:0];
        end else if (v < DW_MIN) begin
            r = DW_MIN[DATA_WIDTH-1:0];
        end else begin
            r = v[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

    logic [28:0] q_angle_reg;
    logic [28:0] q_bias_reg;
    logic [31:0] r_reg;
    logic [28:0] dt_reg;

    logic signed [DATA_WIDTH-1:0] angle_reg;
    logic signed [DATA_WIDTH-1:0] bias_reg;
    logic signed [31:0] p00_reg;
    logic signed [31:0] p01_reg;
    logic signed [31:0] p10_reg;
    logic signed [31:0] p11_reg;

    logic signed [31:0]         accel_reg;
    logic signed [31:0]         gyro_reg;
    logic signed [31:0]         t0_reg;
    logic signed [31:0]         t1_reg;
    logic signed [EW-1:0]       err_reg;
    logic signed [31:0]         k0_reg;
    logic signed [31:0]         k1_reg;

    logic                out_valid_reg;
    logic signed [31:0]  angle_est_reg;
    logic signed [31:0]  rate_est_reg;

    logic signed [WW-1:0]               mul_a;
    logic signed [agbk_pkg::NW-1:0]     mul_b;
    logic                               mul_done;
    logic signed [agbk_pkg::RES_W-1:0]  mul_res;
    logic                               div_done;
    logic signed [31:0]                 div_quo;
    logic signed [31:0]                 div_num;
    logic signed [agbk_pkg::NW-1:0]     e_sum;
    logic                               e_pos;
    logic signed [agbk_pkg::NW-1:0]     d00;
    logic signed [agbk_pkg::NW-1:0]     dt_s;
    logic signed [WW-1:0]               rate_diff;
    logic signed [EW-1:0]               err_now;
    logic signed [31:0]                 k_new;
    logic signed [63:0]                 angle_ext;
    logic signed [63:0]                 bias_ext;

    // Derived terms of the predict and gain steps.
    assign dt_s      = $signed({5'b0, dt_reg});
    assign d00       = $signed({5'b0, q_angle_reg}) - agbk_pkg::NW'(p01_reg)
                       - agbk_pkg::NW'(p10_reg);
    assign e_sum     = $signed({2'b00, r_reg}) + agbk_pkg::NW'(p00_reg);
    assign e_pos     = !e_sum[agbk_pkg::NW-1] && (e_sum != '0);
    assign rate_diff = WW'(gyro_reg) - WW'(bias_reg);
    assign err_now   = EW'(accel_reg) - EW'(angle_reg);
    assign angle_ext = 64'(angle_reg);
    assign bias_ext  = 64'(bias_reg);
    assign div_num   = (cmd.step == agbk_pkg::STEP_K1) ? p10_reg : p00_reg;
    assign k_new     = e_pos ? div_quo : 32'sd0;

    // Multiplier operand selection for each step.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.step)
            agbk_pkg::STEP_ANG_P:  begin mul_a = rate_diff;     mul_b = dt_s; end
            agbk_pkg::STEP_P00:    begin mul_a = WW'(dt_s);     mul_b = d00; end
            agbk_pkg::STEP_P01:    begin mul_a = WW'(dt_s);     mul_b = -agbk_pkg::NW'(p11_reg); end
            agbk_pkg::STEP_P11:    begin mul_a = WW'(dt_s);     mul_b = $signed({5'b0, q_bias_reg}); end
            agbk_pkg::STEP_C_P00:  begin mul_a = WW'(t0_reg);   mul_b = agbk_pkg::NW'(k0_reg); end
            agbk_pkg::STEP_C_P01:  begin mul_a = WW'(t1_reg);   mul_b = agbk_pkg::NW'(k0_reg); end
            agbk_pkg::STEP_C_P10:  begin mul_a = WW'(t0_reg);   mul_b = agbk_pkg::NW'(k1_reg); end
            agbk_pkg::STEP_C_P11:  begin mul_a = WW'(t1_reg);   mul_b = agbk_pkg::NW'(k1_reg); end
            agbk_pkg::STEP_C_ANG:  begin mul_a = WW'(err_reg);  mul_b = agbk_pkg::NW'(k0_reg); end
            agbk_pkg::STEP_C_BIAS: begin mul_a = WW'(err_reg);  mul_b = agbk_pkg::NW'(k1_reg); end
            default:               begin mul_a = '0;            mul_b = '0; end
        endcase
    end

    agbk_mul #(
        .WW (WW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .res   (mul_res)
    );

    agbk_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   ($unsigned(e_sum)),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Configuration registers and filter state with write-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_angle_reg <= agbk_pkg::RST_Q_ANGLE;
            q_bias_reg  <= agbk_pkg::RST_Q_BIAS;
            r_reg       <= agbk_pkg::RST_R;
            dt_reg      <= agbk_pkg::RST_DT;
            angle_reg   <= '0;
            bias_reg    <= '0;
            p00_reg     <= agbk_pkg::Q28_ONE;
            p01_reg     <= '0;
            p10_reg     <= '0;
            p11_reg     <= agbk_pkg::Q28_ONE;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (agbk_pkg::cfg_index_t'(cfg_index))
                    agbk_pkg::CFG_Q_ANGLE: q_angle_reg <= cfg_data[28:0];
                    agbk_pkg::CFG_Q_BIAS:  q_bias_reg  <= cfg_data[28:0];
                    agbk_pkg::CFG_R:       r_reg       <= cfg_data;
                    agbk_pkg::CFG_DT:      dt_reg      <= cfg_data[28:0];
                    default:               r_reg       <= r_reg;
                endcase
            end
            if (cmd.wb)
            begin
                case (cmd.step)
                    agbk_pkg::STEP_ANG_P:  angle_reg <= sat_dw(angle_ext + mul_res);
                    agbk_pkg::STEP_P00:    p00_reg <= agbk_pkg::sat32(64'(p00_reg) + mul_res);
                    agbk_pkg::STEP_P01:
                    begin
                        p01_reg <= agbk_pkg::sat32(64'(p01_reg) + mul_res);
                        p10_reg <= agbk_pkg::sat32(64'(p10_reg) + mul_res);
                    end
                    agbk_pkg::STEP_P11:    p11_reg <= agbk_pkg::sat32(64'(p11_reg) + mul_res);
                    agbk_pkg::STEP_C_P00:  p00_reg <= agbk_pkg::sat32(64'(p00_reg) - mul_res);
                    agbk_pkg::STEP_C_P01:  p01_reg <= agbk_pkg::sat32(64'(p01_reg) - mul_res);
                    agbk_pkg::STEP_C_P10:  p10_reg <= agbk_pkg::sat32(64'(p10_reg) - mul_res);
                    agbk_pkg::STEP_C_P11:  p11_reg <= agbk_pkg::sat32(64'(p11_reg) - mul_res);
                    agbk_pkg::STEP_C_ANG:  angle_reg <= sat_dw(angle_ext + mul_res);
                    agbk_pkg::STEP_C_BIAS: bias_reg  <= sat_dw(bias_ext + mul_res);
                    default:               angle_reg <= angle_reg;
                endcase
            end
        end
    end

    // Sample beat, gains and the values frozen for the correction.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            accel_reg <= accel_angle;
            gyro_reg  <= gyro_rate;
        end
        if (cmd.wb && (cmd.step == agbk_pkg::STEP_K0))
        begin
            k0_reg  <= k_new;
            t0_reg  <= p00_reg;
            t1_reg  <= p01_reg;
            err_reg <= err_now;
        end
        if (cmd.wb && (cmd.step == agbk_pkg::STEP_K1))
        begin
            k1_reg <= k_new;
        end
        if (cmd.out_load)
        begin
            angle_est_reg <= agbk_pkg::sat32(angle_ext);
            rate_est_reg  <= agbk_pkg::sat32(64'(gyro_reg) - bias_ext);
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.mul_done = mul_done;
    assign status.div_done = div_done;
    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid = out_valid_reg;
    assign angle_est = angle_est_reg;
    assign rate_est  = rate_est_reg;

endmodule

// ===== hdl/agbk_ctrl.sv =====
// ----------------------------------------------------------------------------
// agbk_ctrl: filter sequencer
// Walks the fixed list of multiply and divide steps for one sample and hands
// the finished result to the output register.
// ----------------------------------------------------------------------------
module agbk_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  agbk_pkg::status_t     status,
    output agbk_pkg::cmd_t        cmd
);

    agbk_pkg::state_t state_reg;
    agbk_pkg::state_t state_next;
    agbk_pkg::step_t  step_reg;
    agbk_pkg::step_t  step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= agbk_pkg::ST_IDLE;
            step_reg  <= agbk_pkg::STEP_ANG_P;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state and step.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            agbk_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = agbk_pkg::ST_START;
                    step_next  = agbk_pkg::STEP_ANG_P;
                end
            end
            agbk_pkg::ST_START:
            begin
                state_next = agbk_pkg::is_div(step_reg) ? agbk_pkg::ST_DWAIT : agbk_pkg::ST_MWAIT;
            end
            agbk_pkg::ST_MWAIT:
            begin
                if (status.mul_done)
                begin
                    if (step_reg == agbk_pkg::STEP_C_BIAS)
                    begin
                        state_next = agbk_pkg::ST_OUT;
                    end
                    else
                    begin
                        state_next = agbk_pkg::ST_START;
                        step_next  = agbk_pkg::next_step(step_reg);
                    end
                end
            end
            agbk_pkg::ST_DWAIT:
            begin
                if (status.div_done)
                begin
                    state_next = agbk_pkg::ST_START;
                    step_next  = agbk_pkg::next_step(step_reg);
                end
            end
            agbk_pkg::ST_OUT:
            begin
                if (!status.out_busy)
                begin
                    state_next = agbk_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = agbk_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd.step      = step_reg;
        cmd.capture   = (state_reg == agbk_pkg::ST_IDLE) && in_valid;
        cmd.mul_start = (state_reg == agbk_pkg::ST_START) && !agbk_pkg::is_div(step_reg);
        cmd.div_start = (state_reg == agbk_pkg::ST_START) && agbk_pkg::is_div(step_reg);
        cmd.wb        = ((state_reg == agbk_pkg::ST_MWAIT) && status.mul_done)
                        || ((state_reg == agbk_pkg::ST_DWAIT) && status.div_done);
        cmd.out_load  = (state_reg == agbk_pkg::ST_OUT) && !status.out_busy;
        in_ready      = (state_reg == agbk_pkg::ST_IDLE);
    end

endmodule

// ===== hdl/angle_gyro_bias_kalman_core.sv =====
// ----------------------------------------------------------------------------
// angle_gyro_bias_kalman_core: two-state angle / gyro-bias Kalman filter
// Fuses an accelerometer angle with a gyro rate in fixed point and returns
// the filtered angle and the bias-corrected rate for every sample.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  in       | in_valid/in_ready   | accel_angle, gyro_rate (Q16.16)
//  out      | out_valid/out_ready | angle_est, rate_est (Q16.16)
//  cfg      | cfg_we              | cfg_index, cfg_data (Q4.28 registers)
//
// A sample takes 10 multiplies of NCH chunks each (NCH = 3 at the default
// width) and 2 gain divides, plus the accept and output states. The shared
// radix-2 divider and the 16-bit-per-cycle multiplier set the time from one
// input beat to the next.
// Reset loads the register defaults and an identity covariance.
// A new sample is taken while a result waits in the output register; the
// sequencer only stalls at its end while that register is still full.
// ----------------------------------------------------------------------------
module angle_gyro_bias_kalman_core #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  accel_angle,
    input  logic signed [31:0]  gyro_rate,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  angle_est,
    output logic signed [31:0]  rate_est
);

    agbk_pkg::cmd_t    cmd;
    agbk_pkg::status_t status;

    agbk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    agbk_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accel_angle (accel_angle),
        .gyro_rate   (gyro_rate),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .angle_est   (angle_est),
        .rate_est    (rate_est)
    );

`ifndef ASSERT_OFF
    // Once a beat is taken the sequencer is busy for the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after a beat");

    // No arithmetic unit finishes while the block is idle.
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !(status.mul_done || status.div_done))
        else $error("unit finished while idle");

    // A result is only loaded into a free output register.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid && !out_ready))
        else $error("result overwrote a waiting beat");
`endif

endmodule

// ===== tb/tb_angle_gyro_bias_kalman_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_angle_gyro_bias_kalman_core: self-checking bench of the Kalman core
// Streams accelerometer/gyro samples through the core under several noise and
// sample-period settings, predicts each filtered angle and rate in fixed
// point, and compares every output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_angle_gyro_bias_kalman_core;

    localparam longint Q_ONE     = 64'sd268435456;
    localparam int     WDOG_MAX  = 4000;
    localparam int     SETTLE    = 300;

    typedef struct packed {
        logic signed [31:0] accel;
        logic signed [31:0] gyro;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] angle;
        logic signed [31:0] rate;
    } estimate_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = agbk_pkg::CFG_Q_ANGLE;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] accel_angle = '0;
    logic signed [31:0] gyro_rate = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] angle_est;
    logic signed [31:0] rate_est;

    sample_t   sample_queue[$];
    estimate_t estimate_queue[$];
    int        err_count = 0;
    int        samples_in = 0;
    int        estimates_out = 0;
    int        gain_skips = 0;

    // Filter copy: registers and state, kept at 64 bits.
    longint q_angle, q_bias, r_noise, dt_period;
    longint ang_st, bias_st, p00, p01, p10, p11;

    angle_gyro_bias_kalman_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .accel_angle (accel_angle),
        .gyro_rate   (gyro_rate),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .angle_est   (angle_est),
        .rate_est    (rate_est)
    );

    always #5 clk = ~clk;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Q4.28 product, rounded half away from zero, magnitude capped at 2^62.
    function automatic longint q28_product(input longint a, input longint b);
        logic [127:0] prod;
        logic [63:0]  ua;
        logic [63:0]  ub;
        longint       mag;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        prod = {64'd0, ua} * {64'd0, ub};
        prod = (prod + (128'd1 << 27)) >> 28;
        if (prod > (128'd1 << 62)) begin
            prod = 128'd1 << 62;
        end
        mag = prod[63:0];
        return ((a < 0) != (b < 0)) ? -mag : mag;
    endfunction

    // One predict/correct pass of the filter; queues the expected estimate.
    task automatic kalman_update(input sample_t s);
        longint    gyro;
        longint    innov;
        longint    var_e;
        longint    k0;
        longint    k1;
        longint    t0;
        longint    t1;
        longint    rate_sat;
        estimate_t est;
        gyro = s.gyro;
        k0 = 0;
        k1 = 0;
        ang_st = clamp32(ang_st + q28_product(gyro - bias_st, dt_period));
        p00 = clamp32(p00 + q28_product(q_angle - p01 - p10, dt_period));
        p01 = clamp32(p01 + q28_product(-p11, dt_period));
        p10 = clamp32(p10 + q28_product(-p11, dt_period));
        p11 = clamp32(p11 + q28_product(q_bias, dt_period));
        innov = longint'(s.accel) - ang_st;
        var_e = r_noise + p00;
        if (var_e > 0) begin
            k0 = clamp32((p00 * Q_ONE) / var_e);
            k1 = clamp32((p10 * Q_ONE) / var_e);
        end else begin
            gain_skips++;
        end
        t0 = p00;
        t1 = p01;
        p00 = clamp32(p00 - q28_product(k0, t0));
        p01 = clamp32(p01 - q28_product(k0, t1));
        p10 = clamp32(p10 - q28_product(k1, t0));
        p11 = clamp32(p11 - q28_product(k1, t1));
        ang_st = clamp32(ang_st + q28_product(k0, innov));
        bias_st = clamp32(bias_st + q28_product(k1, innov));
        rate_sat = clamp32(gyro - bias_st);
        est.angle = ang_st[31:0];
        est.rate = rate_sat[31:0];
        estimate_queue.push_back(est);
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        logic    hold;
        logic    nv;
        sample_t s;
        if (!rst_n) begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            hold = in_valid;
            if (in_valid && in_ready) begin
                s.accel = accel_angle;
                s.gyro = gyro_rate;
                kalman_update(s);
                samples_in++;
                hold = 1'b0;
            end
            if (!hold) begin
                nv = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (sample_queue.size() > 0) begin
                    s = sample_queue.pop_front();
                    accel_angle <= s.accel;
                    gyro_rate <= s.gyro;
                    nv = 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end else begin
                        burst_left--;
                    end
                end
                in_valid <= nv;
            end
        end
    end

    // Receiver: stall density is picked anew whenever ready_cnt wraps.
    int ready_pct = 100;
    int ready_cnt = 0;
    always @(posedge clk or negedge rst_n)
    begin
        estimate_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                estimates_out++;
                if (estimate_queue.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected beat angle=%0d rate=%0d",
                             $time, angle_est, rate_est);
                end else begin
                    want = estimate_queue.pop_front();
                    if (angle_est !== want.angle) begin
                        err_count++;
                        $display("%0t: angle_est expected %0d actual %0d",
                                 $time, want.angle, angle_est);
                    end
                    if (rate_est !== want.rate) begin
                        err_count++;
                        $display("%0t: rate_est expected %0d actual %0d",
                                 $time, want.rate, rate_est);
                    end
                end
            end
            ready_cnt++;
            if (ready_cnt == 256) begin
                ready_cnt = 0;
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 70;
                    2: ready_pct = 25;
                    default: ready_pct = 5;
                endcase
            end
            out_ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    // Watchdog: cycles with work pending but no beat on either channel.
    int stall_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles = 0;
        end else if (in_valid || sample_queue.size() > 0 || estimate_queue.size() > 0) begin
            stall_cycles++;
            if (stall_cycles >= WDOG_MAX) begin
                $display("%0t: no progress for %0d cycles", $time, WDOG_MAX);
                $display("angle_gyro_bias_kalman_core test failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input agbk_pkg::cfg_index_t idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            agbk_pkg::CFG_Q_ANGLE: q_angle = value & 32'h1FFF_FFFF;
            agbk_pkg::CFG_Q_BIAS:  q_bias = value & 32'h1FFF_FFFF;
            agbk_pkg::CFG_R:       r_noise = value;
            default:               dt_period = value & 32'h1FFF_FFFF;
        endcase
    endtask

    task automatic write_all(input logic [31:0] qa, input logic [31:0] qb,
                             input logic [31:0] r, input logic [31:0] dt);
        write_reg(agbk_pkg::CFG_Q_ANGLE, qa);
        write_reg(agbk_pkg::CFG_Q_BIAS, qb);
        write_reg(agbk_pkg::CFG_R, r);
        write_reg(agbk_pkg::CFG_DT, dt);
    endtask

    // Wait for every queued sample to come back, then let the core settle.
    task automatic drain();
        while (sample_queue.size() > 0 || in_valid || estimate_queue.size() > 0) begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // Mostly a slowly moving tilt with a noisy gyro; some raw full-range beats.
    task automatic queue_random(input int count);
        sample_t s;
        int      tilt;
        int      spin;
        tilt = $urandom_range(0, 180 << 16) - (90 << 16);
        spin = $urandom_range(0, 40 << 16) - (20 << 16);
        repeat (count) begin
            if ($urandom_range(0, 9) < 7) begin
                tilt = tilt + (spin >>> 8);
                s.accel = tilt + $urandom_range(0, 1 << 17) - (1 << 16);
                s.gyro = spin + $urandom_range(0, 1 << 16) - (1 << 15);
                if ($urandom_range(0, 31) == 0) begin
                    spin = $urandom_range(0, 400 << 16) - (200 << 16);
                end
            end else begin
                s.accel = $urandom;
                s.gyro = $urandom;
            end
            sample_queue.push_back(s);
        end
    endtask

    initial
    begin
        sample_t s;
        q_angle = agbk_pkg::RST_Q_ANGLE;
        q_bias = agbk_pkg::RST_Q_BIAS;
        r_noise = agbk_pkg::RST_R;
        dt_period = agbk_pkg::RST_DT;
        ang_st = 0;
        bias_st = 0;
        p00 = Q_ONE;
        p01 = 0;
        p10 = 0;
        p11 = Q_ONE;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes at the reset settings.
        s.accel = 0;           s.gyro = 0;           sample_queue.push_back(s);
        s.accel = 32'h7FFFFFFF; s.gyro = 0;          sample_queue.push_back(s);
        s.accel = 32'h80000000; s.gyro = 0;          sample_queue.push_back(s);
        s.accel = 0;           s.gyro = 32'h7FFFFFFF; sample_queue.push_back(s);
        s.accel = 0;           s.gyro = 32'h80000000; sample_queue.push_back(s);
        s.accel = 32'h7FFFFFFF; s.gyro = 32'h7FFFFFFF; sample_queue.push_back(s);
        s.accel = 32'h80000000; s.gyro = 32'h80000000; sample_queue.push_back(s);
        s.accel = -1;          s.gyro = -1;          sample_queue.push_back(s);
        s.accel = 1;           s.gyro = 1;           sample_queue.push_back(s);
        s.accel = 30 << 16;    s.gyro = 5 << 16;     sample_queue.push_back(s);
        s.accel = -(30 << 16); s.gyro = -(5 << 16);  sample_queue.push_back(s);
        drain();

        // Large noises and period with the smallest nonzero R: saturation paths.
        write_all(32'h1000_0000, 32'h1000_0000, 32'd1, 32'h1000_0000);
        s.accel = 32'h7FFFFFFF; s.gyro = 32'h7FFFFFFF; sample_queue.push_back(s);
        s.accel = 32'h80000000; s.gyro = 32'h80000000; sample_queue.push_back(s);
        queue_random(150);
        drain();

        // Zero noise, smallest nonzero period, largest R.
        write_all(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1);
        queue_random(150);
        drain();

        // Zero R and zero period; upper bits of the 29-bit registers set.
        write_all(32'hE000_0000, 32'hF000_1234, 32'd0, 32'hE000_0000);
        queue_random(120);
        drain();

        // Large period with zero R drives the covariance negative.
        write_all(32'd0, 32'd0, 32'd0, 32'h0800_0000 + $urandom_range(0, 1 << 27));
        queue_random(120);
        drain();

        // Back to the nominal tuning, then a run of random tunings.
        write_all(agbk_pkg::RST_Q_ANGLE, agbk_pkg::RST_Q_BIAS, agbk_pkg::RST_R,
                  agbk_pkg::RST_DT);
        queue_random(180);
        drain();
        repeat (5) begin
            write_all($urandom_range(0, 1 << 28) | ($urandom_range(0, 7) << 29),
                      $urandom_range(0, 1 << 28),
                      ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(1, 1 << 28),
                      ($urandom_range(0, 1) == 0) ? $urandom_range(1, 1 << 23)
                                                  : $urandom_range(1, 1 << 28));
            queue_random(150);
            drain();
        end

        $display("Covered %0d samples and %0d estimates over 11 register settings,",
                 samples_in, estimates_out);
        $display("with %0d samples taking the zero-gain path.", gain_skips);
        if (err_count == 0 && estimate_queue.size() == 0) begin
            $display("angle_gyro_bias_kalman_core test passed");
        end else begin
            $display("angle_gyro_bias_kalman_core test failed");
        end
        $finish;
    end

endmodule
